### hw/rtl/lpd_pkg.sv
// Shared constants and types for the link presence debounce/timeout block.
// No dependencies; imported by the channel interfaces and the top level.

package lpd_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned MS_W     = 16;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned ENERGY_W = 8;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned PHASE_W  = 2;
  localparam int unsigned EVENT_W  = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // item kinds
  localparam logic [MODE_W-1:0] MODE_TICK     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ENERGY   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DISCOVER = 2'd2;

  // link phases (code 3 behaves as debouncing)
  localparam logic [PHASE_W-1:0] PH_DOWN     = 2'd0;
  localparam logic [PHASE_W-1:0] PH_DEBOUNCE = 2'd1;
  localparam logic [PHASE_W-1:0] PH_UP       = 2'd2;

  // link events
  localparam logic [EVENT_W-1:0] EV_NONE = 2'd0;
  localparam logic [EVENT_W-1:0] EV_CONN = 2'd1;
  localparam logic [EVENT_W-1:0] EV_DISC = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEND_INTVL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL  = 2'd3;

  // register reset values
  localparam logic [MS_W-1:0]     DEBOUNCE_RST   = 16'd50;
  localparam logic [MS_W-1:0]     TIMEOUT_RST    = 16'd3000;
  localparam logic [MS_W-1:0]     SEND_INTVL_RST = 16'd1000;
  localparam logic [ENERGY_W-1:0] LOW_LEVEL_RST  = 8'd5;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic                pin_low;
    logic [TIME_W-1:0]   now_ms;
    logic [ID_W-1:0]     partner_id;
    logic [ENERGY_W-1:0] partner_energy;
  } lpd_item_t;

  typedef struct packed {
    logic                send_request;
    logic [EVENT_W-1:0]  link_event;
    logic                link_up;
    logic [ID_W-1:0]     reported_id;
    logic [ENERGY_W-1:0] reported_energy;
    logic                low_energy;
  } lpd_result_t;

endpackage

### hw/rtl/lpd_if.sv
// Valid/ready channel interfaces: input items, result words, register writes.
// Depends on lpd_pkg for field widths.

interface lpd_in_if import lpd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic                pin_low;
  logic [TIME_W-1:0]   now_ms;
  logic [ID_W-1:0]     partner_id;
  logic [ENERGY_W-1:0] partner_energy;

  modport source (output valid, mode, pin_low, now_ms, partner_id, partner_energy,
                  input ready);
  modport sink   (input valid, mode, pin_low, now_ms, partner_id, partner_energy,
                  output ready);
endinterface

interface lpd_out_if import lpd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                send_request;
  logic [EVENT_W-1:0]  link_event;
  logic                link_up;
  logic [ID_W-1:0]     reported_id;
  logic [ENERGY_W-1:0] reported_energy;
  logic                low_energy;

  modport source (output valid, send_request, link_event, link_up, reported_id,
                  reported_energy, low_energy, input ready);
  modport sink   (input valid, send_request, link_event, link_up, reported_id,
                  reported_energy, low_energy, output ready);
endinterface

interface lpd_cfg_if import lpd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/link_presence_debounce_timeout_top.sv
// Link presence detector: pin debounce, message connect, heartbeat timeout.
// Result path: an accepted input word goes into the item register, then the
//   result register, and the result word is valid from the result register.
// Throughput: one word per cycle while the result side accepts; the item
//   register and the result register advance together and hold on out_ch.ready.
// Reset (rst_n low, synchronous): link down, timestamps and partner data
//   zero, registers to defaults, both pipeline stages empty.

module link_presence_debounce_timeout_top
  import lpd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  lpd_in_if.sink       in_ch,
  lpd_out_if.source    out_ch,
  lpd_cfg_if.sink      cfg_ch
);

  // ---------------------------------------------------------------------
  // Configuration registers. Writes are always taken; software must write only
  // while the block is idle, and the block itself does not enforce this.
  // ---------------------------------------------------------------------
  logic [MS_W-1:0]     debounce_ms_r;
  logic [MS_W-1:0]     timeout_ms_r;
  logic [MS_W-1:0]     send_intvl_r;
  logic [ENERGY_W-1:0] low_level_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms_r <= DEBOUNCE_RST;
      timeout_ms_r  <= TIMEOUT_RST;
      send_intvl_r  <= SEND_INTVL_RST;
      low_level_r   <= LOW_LEVEL_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_DEBOUNCE:   debounce_ms_r <= cfg_ch.data;
        REG_TIMEOUT:    timeout_ms_r  <= cfg_ch.data;
        REG_SEND_INTVL: send_intvl_r  <= cfg_ch.data;
        REG_LOW_LEVEL:  low_level_r   <= cfg_ch.data[ENERGY_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline control: item register -> compute -> result register.
  // The item register refills in the same cycle it drains, so a word can
  // enter every cycle while the result side keeps up.
  // ---------------------------------------------------------------------
  lpd_item_t   item_r;
  logic        item_vld_r;
  lpd_result_t res_r;
  lpd_result_t res_nxt;
  logic        out_vld_r;
  logic        adv;
  logic        in_take;

  assign adv          = item_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !item_vld_r || adv;
  assign in_take      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (in_take) begin
        item_vld_r <= 1'b1;
      end else if (adv) begin
        item_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.mode           <= in_ch.mode;
      item_r.pin_low        <= in_ch.pin_low;
      item_r.now_ms         <= in_ch.now_ms;
      item_r.partner_id     <= in_ch.partner_id;
      item_r.partner_energy <= in_ch.partner_energy;
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Link state
  // ---------------------------------------------------------------------
  logic [PHASE_W-1:0]  phase_r,      phase_nxt;
  logic [TIME_W-1:0]   deb_start_r,  deb_start_nxt;
  logic [TIME_W-1:0]   last_heard_r, last_heard_nxt;
  logic [TIME_W-1:0]   last_sent_r,  last_sent_nxt;
  logic [ID_W-1:0]     stored_id_r,  stored_id_nxt;
  logic [ENERGY_W-1:0] stored_en_r,  stored_en_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_DOWN;
      deb_start_r  <= '0;
      last_heard_r <= '0;
      last_sent_r  <= '0;
      stored_id_r  <= '0;
      stored_en_r  <= '0;
    end else if (adv) begin
      phase_r      <= phase_nxt;
      deb_start_r  <= deb_start_nxt;
      last_heard_r <= last_heard_nxt;
      last_sent_r  <= last_sent_nxt;
      stored_id_r  <= stored_id_nxt;
      stored_en_r  <= stored_en_nxt;
    end
  end

  // Wrapping elapsed times against the stored references.
  logic [TIME_W-1:0] since_heard;
  logic [TIME_W-1:0] since_deb;
  logic [TIME_W-1:0] since_sent;
  logic              timed_out;
  logic              deb_done;

  assign since_heard = item_r.now_ms - last_heard_r;
  assign since_deb   = item_r.now_ms - deb_start_r;
  assign timed_out   = since_heard > {{(TIME_W-MS_W){1'b0}}, timeout_ms_r};
  assign deb_done    = since_deb  >= {{(TIME_W-MS_W){1'b0}}, debounce_ms_r};

  // Send interval is measured from the reference as it stands after any
  // connect on this tick (connect moves it to now, giving zero elapsed).
  logic send_due;
  logic dropped;
  logic up_now;

  always_comb begin
    phase_nxt      = phase_r;
    deb_start_nxt  = deb_start_r;
    last_heard_nxt = last_heard_r;
    last_sent_nxt  = last_sent_r;
    stored_id_nxt  = stored_id_r;
    stored_en_nxt  = stored_en_r;
    res_nxt        = '0;
    dropped        = 1'b0;
    since_sent     = '0;
    send_due       = 1'b0;

    unique case (item_r.mode)
      MODE_TICK: begin
        priority if (phase_r == PH_UP && timed_out) begin
          // heartbeat lost: drop and forget the partner
          phase_nxt          = PH_DOWN;
          stored_id_nxt      = '0;
          stored_en_nxt      = '0;
          res_nxt.link_event = EV_DISC;
          dropped            = 1'b1;
        end else if (phase_r == PH_DOWN) begin
          if (item_r.pin_low) begin
            phase_nxt     = PH_DEBOUNCE;
            deb_start_nxt = item_r.now_ms;
          end
        end else if (phase_r != PH_UP) begin
          // debouncing (and the unused code)
          if (!item_r.pin_low) begin
            phase_nxt = PH_DOWN;
          end else if (deb_done) begin
            phase_nxt            = PH_UP;
            last_heard_nxt       = item_r.now_ms;
            last_sent_nxt        = item_r.now_ms;
            res_nxt.link_event   = EV_CONN;
            res_nxt.send_request = 1'b1;
          end
        end else begin
          // up and still hearing the partner
        end
        since_sent = item_r.now_ms - last_sent_nxt;
        send_due   = since_sent >= {{(TIME_W-MS_W){1'b0}}, send_intvl_r};
        if (!dropped && phase_nxt == PH_UP && send_due) begin
          res_nxt.send_request = 1'b1;
          last_sent_nxt        = item_r.now_ms;
        end
      end
      MODE_ENERGY: begin
        stored_id_nxt      = item_r.partner_id;
        stored_en_nxt      = item_r.partner_energy;
        last_heard_nxt     = item_r.now_ms;
        res_nxt.low_energy = item_r.partner_energy <= low_level_r;
        if (phase_r != PH_UP) begin
          phase_nxt            = PH_UP;
          last_sent_nxt        = item_r.now_ms;
          res_nxt.link_event   = EV_CONN;
          res_nxt.send_request = 1'b1;
        end
      end
      MODE_DISCOVER: begin
        if (phase_r != PH_UP) begin
          phase_nxt            = PH_UP;
          last_heard_nxt       = item_r.now_ms;
          last_sent_nxt        = item_r.now_ms;
          res_nxt.link_event   = EV_CONN;
          res_nxt.send_request = 1'b1;
        end
      end
      default: ; // unused kind: status only, state untouched
    endcase

    up_now                  = phase_nxt == PH_UP;
    res_nxt.link_up         = up_now;
    res_nxt.reported_id     = up_now ? stored_id_nxt : '0;
    res_nxt.reported_energy = up_now ? stored_en_nxt : '0;
  end

  // ---------------------------------------------------------------------
  // Result word
  // ---------------------------------------------------------------------
  assign out_ch.valid           = out_vld_r;
  assign out_ch.send_request    = res_r.send_request;
  assign out_ch.link_event      = res_r.link_event;
  assign out_ch.link_up         = res_r.link_up;
  assign out_ch.reported_id     = res_r.reported_id;
  assign out_ch.reported_energy = res_r.reported_energy;
  assign out_ch.low_energy      = res_r.low_energy;

endmodule

### sim/lpd_link_checker.sv
// Scoreboard for the link presence block: follows the link state from the
// accepted input words and register writes, predicts every result word and
// compares it. Depends on lpd_pkg and the channel interfaces in lpd_if.

module lpd_link_checker
  import lpd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  lpd_in_if    in_ch,
  lpd_out_if   out_ch,
  lpd_cfg_if   cfg_ch,
  output int   fail_count,
  output int   words_pending
);

  localparam int PRINT_CAP = 100;

  // shadow registers
  logic [MS_W-1:0]     debounce_ms;
  logic [MS_W-1:0]     timeout_ms;
  logic [MS_W-1:0]     interval_ms;
  logic [ENERGY_W-1:0] low_level;

  // shadow link state
  logic [PHASE_W-1:0]  phase;
  logic [TIME_W-1:0]   debounce_t0;
  logic [TIME_W-1:0]   heard_ms;
  logic [TIME_W-1:0]   sent_ms;
  logic [ID_W-1:0]     partner;
  logic [ENERGY_W-1:0] energy;

  lpd_result_t expected_status_q[$];
  int n_fail = 0;
  int n_pending = 0;

  assign fail_count    = n_fail;
  assign words_pending = n_pending;

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    n_fail++;
    if (n_fail <= PRINT_CAP)
      $display("[%0t] mismatch %s: got %0h, want %0h", $time, what, got, want);
  endtask

  function automatic void bring_up(input logic [TIME_W-1:0] now);
    phase    = PH_UP;
    heard_ms = now;
    sent_ms  = now;
  endfunction

  // One input word in, one status word out; updates the shadow state.
  function automatic lpd_result_t step_link(input lpd_item_t w);
    lpd_result_t r;
    logic        dropped;
    logic [TIME_W-1:0] since;
    r = '0;
    dropped = 1'b0;
    case (w.mode)
      MODE_TICK: begin
        since = w.now_ms - heard_ms;
        if (phase == PH_UP && since > TIME_W'(timeout_ms)) begin
          phase        = PH_DOWN;
          partner      = '0;
          energy       = '0;
          r.link_event = EV_DISC;
          dropped      = 1'b1;
        end else if (phase == PH_DOWN) begin
          if (w.pin_low) begin
            phase       = PH_DEBOUNCE;
            debounce_t0 = w.now_ms;
          end
        end else if (phase != PH_UP) begin
          since = w.now_ms - debounce_t0;
          if (!w.pin_low) begin
            phase = PH_DOWN;
          end else if (since >= TIME_W'(debounce_ms)) begin
            bring_up(w.now_ms);
            r.link_event   = EV_CONN;
            r.send_request = 1'b1;
          end
        end
        since = w.now_ms - sent_ms;
        if (!dropped && phase == PH_UP && since >= TIME_W'(interval_ms)) begin
          r.send_request = 1'b1;
          sent_ms        = w.now_ms;
        end
      end
      MODE_ENERGY: begin
        partner      = w.partner_id;
        energy       = w.partner_energy;
        heard_ms     = w.now_ms;
        r.low_energy = (w.partner_energy <= low_level);
        if (phase != PH_UP) begin
          bring_up(w.now_ms);
          r.link_event   = EV_CONN;
          r.send_request = 1'b1;
        end
      end
      MODE_DISCOVER: begin
        if (phase != PH_UP) begin
          bring_up(w.now_ms);
          r.link_event   = EV_CONN;
          r.send_request = 1'b1;
        end
      end
      default: ;  // unused kind: status only
    endcase
    r.link_up         = (phase == PH_UP);
    r.reported_id     = r.link_up ? partner : '0;
    r.reported_energy = r.link_up ? energy : '0;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    lpd_item_t   word_in;
    lpd_result_t got;
    lpd_result_t want;
    if (!rst_n) begin
      debounce_ms = DEBOUNCE_RST;
      timeout_ms  = TIMEOUT_RST;
      interval_ms = SEND_INTVL_RST;
      low_level   = LOW_LEVEL_RST;
      phase       = PH_DOWN;
      debounce_t0 = '0;
      heard_ms    = '0;
      sent_ms     = '0;
      partner     = '0;
      energy      = '0;
      expected_status_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_DEBOUNCE:   debounce_ms = cfg_ch.data;
          REG_TIMEOUT:    timeout_ms  = cfg_ch.data;
          REG_SEND_INTVL: interval_ms = cfg_ch.data;
          REG_LOW_LEVEL:  low_level   = cfg_ch.data[ENERGY_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got.send_request    = out_ch.send_request;
        got.link_event      = out_ch.link_event;
        got.link_up         = out_ch.link_up;
        got.reported_id     = out_ch.reported_id;
        got.reported_energy = out_ch.reported_energy;
        got.low_energy      = out_ch.low_energy;
        if (expected_status_q.size() == 0) begin
          flag_mismatch("word with nothing pending", 32'(got), '0);
        end else begin
          want = expected_status_q.pop_front();
          if (got.send_request !== want.send_request)
            flag_mismatch("send_request", 32'(got.send_request), 32'(want.send_request));
          if (got.link_event !== want.link_event)
            flag_mismatch("link_event", 32'(got.link_event), 32'(want.link_event));
          if (got.link_up !== want.link_up)
            flag_mismatch("link_up", 32'(got.link_up), 32'(want.link_up));
          if (got.reported_id !== want.reported_id)
            flag_mismatch("reported_id", 32'(got.reported_id), 32'(want.reported_id));
          if (got.reported_energy !== want.reported_energy)
            flag_mismatch("reported_energy", 32'(got.reported_energy),
                          32'(want.reported_energy));
          if (got.low_energy !== want.low_energy)
            flag_mismatch("low_energy", 32'(got.low_energy), 32'(want.low_energy));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        word_in.mode           = in_ch.mode;
        word_in.pin_low        = in_ch.pin_low;
        word_in.now_ms         = in_ch.now_ms;
        word_in.partner_id     = in_ch.partner_id;
        word_in.partner_energy = in_ch.partner_energy;
        expected_status_q.push_back(step_link(word_in));
      end
    end
    n_pending = expected_status_q.size();
  end

endmodule

### sim/tb_top.sv
// Testbench top for link_presence_debounce_timeout_top: clock, reset,
// directed and random input words, register phases, result back-pressure.
// Depends on lpd_pkg, lpd_if and the lpd_link_checker scoreboard.

module tb_top;
  import lpd_pkg::*;

  // word kind the block must ignore (reports status only)
  localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

  localparam int N_PHASES         = 8;
  localparam int RANDOM_PER_PHASE = 225;  // 8 x 225 = 1800 counted random words, ignored kinds not counted
  localparam int SQUEEZE_AFTER    = 500;  // words sent before the long hold-off
  localparam int SQUEEZE_CYCLES   = 400;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int fail_count;
  int words_pending;
  int words_sent = 0;

  bit quiet        = 1'b0;  // phase with no idling on either side
  bit squeeze_done = 1'b0;

  // stimulus shaping state
  logic [TIME_W-1:0]   clock_ms  = '0;
  logic                pin_level = 1'b0;
  int unsigned         span_ms   = 3000;
  int unsigned         msg_pct   = 30;
  logic [ENERGY_W-1:0] level_now = LOW_LEVEL_RST;

  always #5 clk = ~clk;

  lpd_in_if  in_ch ();
  lpd_out_if out_ch ();
  lpd_cfg_if cfg_ch ();

  link_presence_debounce_timeout_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  lpd_link_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  // Watchdog. The timeout covers the slowest correct run: every word with its
  // worst send gap and result stall, plus the long hold-off and the drains,
  // with plenty of margin.
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Idle length: mostly none, sometimes short, rarely long.
  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side: random ready stalls, plus one long hold-off once the
  // sender is well under way, so the pipeline fills and in_ch.ready drops.
  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!squeeze_done && words_sent >= SQUEEZE_AFTER) begin
        squeeze_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(negedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  // valid stays high between back-to-back words.
  task automatic send_word(input lpd_item_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.mode           <= w.mode;
    in_ch.pin_low        <= w.pin_low;
    in_ch.now_ms         <= w.now_ms;
    in_ch.partner_id     <= w.partner_id;
    in_ch.partner_energy <= w.partner_energy;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic put_word(input logic [MODE_W-1:0] mode, input logic pin,
                          input logic [TIME_W-1:0] now, input logic [ID_W-1:0] id,
                          input logic [ENERGY_W-1:0] en);
    lpd_item_t w;
    w.mode           = mode;
    w.pin_low        = pin;
    w.now_ms         = now;
    w.partner_id     = id;
    w.partner_energy = en;
    send_word(w);
  endtask

  // Register write; valid is left high so writes go back to back.
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending, wait for every pending result word, then let the
  // two-stage pipeline settle before touching registers or ending.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_setting(input logic [MS_W-1:0] deb, input logic [MS_W-1:0] tmo,
                               input logic [MS_W-1:0] intvl,
                               input logic [CFG_DATA_W-1:0] lvl);
    drain();
    put_reg(REG_DEBOUNCE, deb);
    put_reg(REG_TIMEOUT, tmo);
    put_reg(REG_SEND_INTVL, intvl);
    put_reg(REG_LOW_LEVEL, lvl);
    cfg_ch.valid <= 1'b0;
    // time steps scale with the largest interval in force
    span_ms = 32'(deb);
    if (32'(tmo) > span_ms) span_ms = 32'(tmo);
    if (32'(intvl) > span_ms) span_ms = 32'(intvl);
    level_now = lvl[ENERGY_W-1:0];
  endtask

  // One random word. Time mostly moves forward by steps sized to the current
  // registers (short, medium, past the timeout), now and then jumps anywhere.
  // The pin level is sticky so debounce windows actually complete.
  task automatic random_word(output bit counted);
    lpd_item_t   w;
    int unsigned roll;
    int unsigned step_roll;
    roll      = $urandom_range(0, 99);
    step_roll = $urandom_range(0, 99);
    if (step_roll < 55)
      clock_ms += $urandom_range(0, span_ms / 8 + 1);
    else if (step_roll < 85)
      clock_ms += $urandom_range(0, span_ms / 2 + 1);
    else if (step_roll < 97)
      clock_ms += $urandom_range(span_ms / 2, span_ms * 2 + 2);
    else
      clock_ms = $urandom();
    w.now_ms     = clock_ms;
    w.partner_id = ID_W'($urandom_range(0, 255));
    // half the energies sit right around the low-energy threshold
    if ($urandom_range(0, 1) != 0)
      w.partner_energy = level_now + ENERGY_W'($urandom_range(0, 2)) - 8'd1;
    else
      w.partner_energy = ENERGY_W'($urandom_range(0, 255));
    w.pin_low = 1'($urandom_range(0, 1));  // noise on non-tick words
    if (roll < 3) begin
      w.mode = MODE_IGNORED;
    end else if (roll < 100 - msg_pct) begin
      w.mode = MODE_TICK;
      if ($urandom_range(0, 7) == 0) pin_level = !pin_level;
      w.pin_low = pin_level;
    end else if (roll < 100 - msg_pct / 3) begin
      w.mode = MODE_ENERGY;
    end else begin
      w.mode = MODE_DISCOVER;
    end
    counted = (w.mode != MODE_IGNORED);
    send_word(w);
  endtask

  initial begin : stimulus
    int n;
    bit counted;
    in_ch.valid          = 1'b0;
    in_ch.mode           = MODE_TICK;
    in_ch.pin_low        = 1'b0;
    in_ch.now_ms         = '0;
    in_ch.partner_id     = '0;
    in_ch.partner_energy = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = REG_DEBOUNCE;
    cfg_ch.data          = '0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, reset registers (debounce 50, timeout 3000,
    // send interval 1000, low level 5).
    put_word(MODE_TICK, 1'b1, 32'd0, 8'd0, 8'd0);        // debounce starts, no connect
    put_word(MODE_TICK, 1'b1, 32'd49, 8'd0, 8'd0);       // one short of debounce
    put_word(MODE_TICK, 1'b1, 32'd50, 8'd0, 8'd0);       // connect + send
    put_word(MODE_TICK, 1'b0, 32'd60, 8'd0, 8'd0);       // up, pin ignored, no send
    put_word(MODE_ENERGY, 1'b0, 32'd100, 8'hFF, 8'd5);   // at low level -> flag
    put_word(MODE_ENERGY, 1'b1, 32'd200, 8'd0, 8'd6);    // just above low level
    put_word(MODE_ENERGY, 1'b0, 32'd300, 8'hA5, 8'hFF);
    put_word(MODE_DISCOVER, 1'b0, 32'd400, 8'h5A, 8'd0); // discover while up: no-op
    put_word(MODE_TICK, 1'b0, 32'd1050, 8'd0, 8'd0);     // periodic send
    put_word(MODE_IGNORED, 1'b1, 32'd1100, 8'hFF, 8'hFF);
    put_word(MODE_TICK, 1'b0, 32'd3301, 8'd0, 8'd0);     // silence > timeout: drop, no send
    put_word(MODE_TICK, 1'b1, 32'd3400, 8'd0, 8'd0);     // debounce again
    put_word(MODE_TICK, 1'b0, 32'd3420, 8'd0, 8'd0);     // pin released -> down
    put_word(MODE_DISCOVER, 1'b0, 32'd3500, 8'd0, 8'd0); // discover connects
    put_word(MODE_TICK, 1'b1, 32'd6501, 8'd0, 8'd0);     // timeout after discover connect
    put_word(MODE_ENERGY, 1'b0, 32'hFFFF_FFF0, 8'd1, 8'd0); // message connects
    put_word(MODE_TICK, 1'b0, 32'h0000_03E8, 8'd0, 8'd0);   // send across time wrap
    put_word(MODE_TICK, 1'b0, 32'h0000_0BD8, 8'd0, 8'd0);   // drop across time wrap
    put_word(MODE_TICK, 1'b1, 32'hFFFF_FFFF, 8'd0, 8'd0);   // debounce from max time
    put_word(MODE_TICK, 1'b1, 32'd49, 8'd0, 8'd0);          // wraps to exactly 50
    put_word(MODE_IGNORED, 1'b0, 32'd60, 8'd0, 8'd0);       // ignored while up

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      msg_pct = (ph % 2 == 0) ? 30 : 12;
      case (ph)
        1: apply_setting(16'd0, 16'd0, 16'd1, 16'h0000);
        2: apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: apply_setting(16'd0, 16'hFFFF, 16'd0, 16'h00FF);     // send on every tick that leaves the link up
        4: apply_setting(MS_W'($urandom_range(0, 2000)), MS_W'($urandom_range(0, 2000)),
                         MS_W'($urandom_range(1, 2000)),
                         CFG_DATA_W'($urandom_range(0, 65535)));
        5: apply_setting(16'd10, 16'd200, 16'd50, 16'h0080);
        6: apply_setting(MS_W'($urandom_range(0, 65535)), MS_W'($urandom_range(0, 65535)),
                         MS_W'($urandom_range(1, 65535)),
                         CFG_DATA_W'($urandom_range(0, 65535)));
        7: apply_setting(16'hFFFF, 16'd0, 16'd1, 16'h0000);
        default: ;  // first phase runs on the reset values
      endcase
      quiet = (ph == 3);
      // sometimes start just below the 32-bit wrap of the time stamp
      if ($urandom_range(0, 3) == 0)
        clock_ms = 32'hFFFF_FFFF - $urandom_range(0, span_ms * 4 + 3);
      n = 0;
      while (n < RANDOM_PER_PHASE) begin
        random_word(counted);
        if (counted) n++;
      end
    end

    drain();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
